[src/plx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plx_pkg
// Shared types and constants for the punctuation lexer: token kinds, scan
// modes, byte codes and the result item layout.
// ----------------------------------------------------------------------------
package plx_pkg;

   // token kinds
   localparam logic [4:0] K_COLON         = 5'd0;
   localparam logic [4:0] K_LPAREN        = 5'd1;
   localparam logic [4:0] K_RPAREN        = 5'd2;
   localparam logic [4:0] K_LBRACE        = 5'd3;
   localparam logic [4:0] K_RBRACE        = 5'd4;
   localparam logic [4:0] K_COMMA         = 5'd5;
   localparam logic [4:0] K_DOT           = 5'd6;
   localparam logic [4:0] K_MINUS         = 5'd7;
   localparam logic [4:0] K_PLUS          = 5'd8;
   localparam logic [4:0] K_SEMI          = 5'd9;
   localparam logic [4:0] K_NEWLINE       = 5'd10;
   localparam logic [4:0] K_TAB           = 5'd11;
   localparam logic [4:0] K_STAR          = 5'd12;
   localparam logic [4:0] K_SLASH         = 5'd13;
   localparam logic [4:0] K_BANG          = 5'd14;
   localparam logic [4:0] K_BANG_EQUAL    = 5'd15;
   localparam logic [4:0] K_EQUAL         = 5'd16;
   localparam logic [4:0] K_EQUAL_EQUAL   = 5'd17;
   localparam logic [4:0] K_LESS          = 5'd18;
   localparam logic [4:0] K_LESS_EQUAL    = 5'd19;
   localparam logic [4:0] K_GREATER       = 5'd20;
   localparam logic [4:0] K_GREATER_EQUAL = 5'd21;
   localparam logic [4:0] K_STRING        = 5'd22;
   localparam logic [4:0] K_UNKNOWN       = 5'd23;
   localparam logic [4:0] K_UNTERMINATED  = 5'd24;

   // scan modes
   localparam logic [3:0] MODE_NORMAL      = 4'd0;
   localparam logic [3:0] MODE_BANG        = 4'd1;
   localparam logic [3:0] MODE_EQUAL       = 4'd2;
   localparam logic [3:0] MODE_LESS        = 4'd3;
   localparam logic [3:0] MODE_GREATER     = 4'd4;
   localparam logic [3:0] MODE_SLASH       = 4'd5;
   localparam logic [3:0] MODE_LINECOMMENT = 4'd6;
   localparam logic [3:0] MODE_BLOCK       = 4'd7;
   localparam logic [3:0] MODE_BLOCKSTAR   = 4'd8;
   localparam logic [3:0] MODE_STRING      = 4'd9;

   // byte codes
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LESS    = 8'h3C;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_GREATER = 8'h3E;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;

   localparam logic [15:0] SAT16    = 16'hFFFF;
   localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [23:0] line_number;
      logic [15:0] column;
      logic [23:0] start_index;
      logic [15:0] token_length;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } step_type;

endpackage
`default_nettype wire

[src/plx_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plx_scan
// Scanner state and the per-byte next-state and token logic. One byte is
// taken per enabled cycle; up to two result items come out combinationally.
// ----------------------------------------------------------------------------
module plx_scan #(
   parameter int POSITION_BITS = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  wire logic [7:0]           char_code,
   input  wire logic                 end_of_file,
   output plx_pkg::step_type         step_out
);

   localparam int PB = POSITION_BITS;

   logic [3:0]    mode_ff,   mode_in;
   logic [PB-1:0] pos_ff,    pos_in;
   logic [23:0]   line_ff,   line_in;
   logic [PB-1:0] lstart_ff, lstart_in;
   logic [PB-1:0] tstart_ff, tstart_in;
   logic [15:0]   tcol_ff,   tcol_in;

   function automatic logic [15:0] col_of(input logic [PB-1:0] p, input logic [PB-1:0] ls);
      logic [32:0] d;
      d = 33'(p - ls) + 33'd1;
      if (p < ls) col_of = 16'd1;
      else if (d > 33'(plx_pkg::SAT16)) col_of = plx_pkg::SAT16;
      else col_of = d[15:0];
   endfunction

   function automatic logic [15:0] len_of(input logic [PB-1:0] p, input logic [PB-1:0] ts);
      logic [32:0] d;
      d = 33'(p - ts) + 33'd1;
      if (d > 33'(plx_pkg::SAT16)) len_of = plx_pkg::SAT16;
      else len_of = d[15:0];
   endfunction

   function automatic logic [4:0] pending_kind(input logic [3:0] m);
      case (m)
         plx_pkg::MODE_BANG:    pending_kind = plx_pkg::K_BANG;
         plx_pkg::MODE_EQUAL:   pending_kind = plx_pkg::K_EQUAL;
         plx_pkg::MODE_LESS:    pending_kind = plx_pkg::K_LESS;
         plx_pkg::MODE_GREATER: pending_kind = plx_pkg::K_GREATER;
         default:               pending_kind = plx_pkg::K_SLASH;
      endcase
   endfunction

   // {hit, kind} for one-byte tokens
   function automatic logic [5:0] single_kind(input logic [7:0] c);
      case (c)
         plx_pkg::CH_COLON:  single_kind = {1'b1, plx_pkg::K_COLON};
         plx_pkg::CH_LPAREN: single_kind = {1'b1, plx_pkg::K_LPAREN};
         plx_pkg::CH_RPAREN: single_kind = {1'b1, plx_pkg::K_RPAREN};
         plx_pkg::CH_LBRACE: single_kind = {1'b1, plx_pkg::K_LBRACE};
         plx_pkg::CH_RBRACE: single_kind = {1'b1, plx_pkg::K_RBRACE};
         plx_pkg::CH_COMMA:  single_kind = {1'b1, plx_pkg::K_COMMA};
         plx_pkg::CH_DOT:    single_kind = {1'b1, plx_pkg::K_DOT};
         plx_pkg::CH_MINUS:  single_kind = {1'b1, plx_pkg::K_MINUS};
         plx_pkg::CH_PLUS:   single_kind = {1'b1, plx_pkg::K_PLUS};
         plx_pkg::CH_SEMI:   single_kind = {1'b1, plx_pkg::K_SEMI};
         plx_pkg::CH_TAB:    single_kind = {1'b1, plx_pkg::K_TAB};
         plx_pkg::CH_STAR:   single_kind = {1'b1, plx_pkg::K_STAR};
         default:            single_kind = 6'd0;
      endcase
   endfunction

   function automatic plx_pkg::result_type mk(input logic [4:0] k, input logic [23:0] ln,
                                              input logic [15:0] col, input logic [PB-1:0] st,
                                              input logic [15:0] len);
      plx_pkg::result_type r;
      r.token_kind   = k;
      r.line_number  = ln;
      r.column       = col;
      r.start_index  = 24'(st);
      r.token_length = len;
      r.last_of_run  = 1'b0;
      mk = r;
   endfunction

   logic [23:0]         line_adv, line_mid;
   logic [PB-1:0]       pos_adv;
   logic [15:0]         cur_col;
   logic [3:0]          mode_mid;
   logic [PB-1:0]       tstart_mid;
   logic [15:0]         tcol_mid;
   logic                consumed, nl;
   logic [5:0]          sk;
   logic                a_vld, b_vld, c_vld;
   plx_pkg::result_type a_res, b_res, c_res;
   plx_pkg::step_type   st;

   always_comb begin
      line_adv   = (line_ff == plx_pkg::LINE_MAX) ? line_ff : line_ff + 24'd1;
      pos_adv    = (pos_ff == {PB{1'b1}}) ? pos_ff : pos_ff + PB'(1);
      cur_col    = col_of(pos_ff, lstart_ff);
      mode_mid   = mode_ff;
      tstart_mid = tstart_ff;
      tcol_mid   = tcol_ff;
      consumed   = 1'b1;
      nl         = 1'b0;
      a_vld      = 1'b0;
      b_vld      = 1'b0;
      c_vld      = 1'b0;
      a_res      = '0;
      b_res      = '0;
      c_res      = '0;
      sk         = single_kind(char_code);

      // bytes that finish or continue a pending construct
      case (mode_ff)
         plx_pkg::MODE_BANG, plx_pkg::MODE_EQUAL, plx_pkg::MODE_LESS,
         plx_pkg::MODE_GREATER: begin
            mode_mid = plx_pkg::MODE_NORMAL;
            a_vld    = 1'b1;
            if (char_code == plx_pkg::CH_EQUAL) begin
               a_res = mk(pending_kind(mode_ff) + 5'd1, line_ff, tcol_ff, tstart_ff, 16'd2);
            end else begin
               a_res    = mk(pending_kind(mode_ff), line_ff, tcol_ff, tstart_ff, 16'd1);
               consumed = 1'b0;
            end
         end
         plx_pkg::MODE_SLASH: begin
            if (char_code == plx_pkg::CH_SLASH) begin
               mode_mid = plx_pkg::MODE_LINECOMMENT;
            end else if (char_code == plx_pkg::CH_STAR) begin
               mode_mid = plx_pkg::MODE_BLOCK;
            end else begin
               mode_mid = plx_pkg::MODE_NORMAL;
               a_vld    = 1'b1;
               a_res    = mk(plx_pkg::K_SLASH, line_ff, tcol_ff, tstart_ff, 16'd1);
               consumed = 1'b0;
            end
         end
         plx_pkg::MODE_LINECOMMENT: begin
            if (char_code == plx_pkg::CH_NEWLINE) begin
               mode_mid = plx_pkg::MODE_NORMAL;
               consumed = 1'b0;
            end
         end
         plx_pkg::MODE_BLOCK: begin
            if (char_code == plx_pkg::CH_STAR) mode_mid = plx_pkg::MODE_BLOCKSTAR;
            else if (char_code == plx_pkg::CH_NEWLINE) nl = 1'b1;
         end
         plx_pkg::MODE_BLOCKSTAR: begin
            if (char_code == plx_pkg::CH_SLASH) begin
               mode_mid = plx_pkg::MODE_NORMAL;
            end else if (char_code != plx_pkg::CH_STAR) begin
               mode_mid = plx_pkg::MODE_BLOCK;
               nl       = (char_code == plx_pkg::CH_NEWLINE);
            end
         end
         plx_pkg::MODE_STRING: begin
            if (char_code == plx_pkg::CH_QUOTE) begin
               mode_mid = plx_pkg::MODE_NORMAL;
               a_vld    = 1'b1;
               a_res    = mk(plx_pkg::K_STRING, line_ff, tcol_ff, tstart_ff,
                             len_of(pos_ff, tstart_ff));
            end else if (char_code == plx_pkg::CH_NEWLINE) begin
               nl = 1'b1;
            end
         end
         default: begin
            mode_mid = plx_pkg::MODE_NORMAL;
            consumed = 1'b0;
         end
      endcase

      // byte in normal context
      if (!consumed) begin
         if (sk[5]) begin
            b_vld = 1'b1;
            b_res = mk(sk[4:0], line_ff, cur_col, pos_ff, 16'd1);
         end else begin
            case (char_code)
               plx_pkg::CH_NEWLINE: begin
                  nl    = 1'b1;
                  b_vld = 1'b1;
                  b_res = mk(plx_pkg::K_NEWLINE, line_adv, cur_col, pos_ff, 16'd1);
               end
               plx_pkg::CH_BANG:    mode_mid = plx_pkg::MODE_BANG;
               plx_pkg::CH_EQUAL:   mode_mid = plx_pkg::MODE_EQUAL;
               plx_pkg::CH_LESS:    mode_mid = plx_pkg::MODE_LESS;
               plx_pkg::CH_GREATER: mode_mid = plx_pkg::MODE_GREATER;
               plx_pkg::CH_SLASH:   mode_mid = plx_pkg::MODE_SLASH;
               plx_pkg::CH_QUOTE:   mode_mid = plx_pkg::MODE_STRING;
               default: begin
                  b_vld = 1'b1;
                  b_res = mk(plx_pkg::K_UNKNOWN, line_ff, cur_col, pos_ff, 16'd1);
               end
            endcase
            if (char_code == plx_pkg::CH_BANG || char_code == plx_pkg::CH_EQUAL ||
                char_code == plx_pkg::CH_LESS || char_code == plx_pkg::CH_GREATER ||
                char_code == plx_pkg::CH_SLASH || char_code == plx_pkg::CH_QUOTE) begin
               tstart_mid = pos_ff;
               tcol_mid   = cur_col;
            end
         end
      end

      line_mid = nl ? line_adv : line_ff;

      // flush at end of file
      if (end_of_file) begin
         if (mode_mid >= plx_pkg::MODE_BANG && mode_mid <= plx_pkg::MODE_SLASH) begin
            c_vld = 1'b1;
            c_res = mk(pending_kind(mode_mid), line_mid, tcol_mid, tstart_mid, 16'd1);
         end else if (mode_mid == plx_pkg::MODE_STRING) begin
            c_vld = 1'b1;
            c_res = mk(plx_pkg::K_UNTERMINATED, line_mid, tcol_mid, tstart_mid,
                       len_of(pos_ff, tstart_mid));
         end
      end

      st.count = {1'b0, a_vld} + {1'b0, b_vld} + {1'b0, c_vld};
      st.r0    = a_vld ? a_res : (b_vld ? b_res : c_res);
      st.r1    = (a_vld && b_vld) ? b_res : c_res;
      if (st.count == 2'd1) st.r0.last_of_run = 1'b1;
      if (st.count == 2'd2) st.r1.last_of_run = 1'b1;

      if (end_of_file) begin
         mode_in   = plx_pkg::MODE_NORMAL;
         pos_in    = '0;
         line_in   = 24'd1;
         lstart_in = '0;
         tstart_in = '0;
         tcol_in   = 16'd1;
      end else begin
         mode_in   = mode_mid;
         pos_in    = pos_adv;
         line_in   = line_mid;
         lstart_in = nl ? pos_adv : lstart_ff;
         tstart_in = tstart_mid;
         tcol_in   = tcol_mid;
      end
   end

   assign step_out = st;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= plx_pkg::MODE_NORMAL;
         pos_ff    <= '0;
         line_ff   <= 24'd1;
         lstart_ff <= '0;
         tstart_ff <= '0;
         tcol_ff   <= 16'd1;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         lstart_ff <= lstart_in;
         tstart_ff <= tstart_in;
         tcol_ff   <= tcol_in;
      end
   end

endmodule
`default_nettype wire

[src/punctuation_lexer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// punctuation_lexer_unit
// Byte-stream lexer for punctuation, operators, comments and strings.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one source byte per item in req_tdata, req_tlast marks the
//   final byte of a file. After that byte the scanner returns to its start
//   state, so the next byte begins a new file at line 1, index 0.
//   rsp_ channel: one token per item. rsp_tuser carries the token kind,
//   rsp_tdata the line, column, start index and length, and rsp_tlast marks
//   the final token caused by one input byte.
//   Throughput: one byte per cycle while rsp_tready is high and each byte
//   yields at most one token; a byte yielding two tokens holds the next
//   byte until its first token is taken. Bytes inside comments or strings
//   yield none and flow at one per cycle once earlier tokens are taken.
//   Stalls: while rsp_tready is low and a token waits, the input register
//   and the two-entry result register hold their contents; req_tready drops
//   while a byte waits in the input register with no room for its tokens.
//   Reset: synchronous; clears the scanner state and empties both registers.
// ----------------------------------------------------------------------------
module punctuation_lexer_unit #(
   parameter int POSITION_BITS = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tlast,   // end_of_file
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [79:0] rsp_tdata,   // [23:0] line_number, [39:24] column,
                                         // [63:40] start_index, [79:64] token_length
   output      logic [4:0]  rsp_tuser,   // [4:0] token_kind
   output      logic        rsp_tlast    // last_of_run
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_char_ff;
   logic                in_eof_ff;
   logic [1:0]          cnt_ff, cnt_in;
   plx_pkg::result_type slot0_ff, slot0_in;
   plx_pkg::result_type slot1_ff, slot1_in;
   plx_pkg::step_type   step_res;
   logic                step, pop, req_acc;

   assign pop     = rsp_tvalid && rsp_tready;
   assign step    = in_valid_ff && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && rsp_tready));
   assign req_acc = req_tvalid && req_tready;

   assign req_tready = !in_valid_ff || step;

   plx_scan #(
      .POSITION_BITS (POSITION_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step),
      .char_code   (in_char_ff),
      .end_of_file (in_eof_ff),
      .step_out    (step_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_acc) in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;

      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (step) begin
         cnt_in   = step_res.count;
         slot0_in = step_res.r0;
         slot1_in = step_res.r1;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_char_ff <= req_tdata;
         in_eof_ff  <= req_tlast;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tuser  = slot0_ff.token_kind;
   assign rsp_tdata  = {slot0_ff.token_length, slot0_ff.start_index,
                        slot0_ff.column, slot0_ff.line_number};
   assign rsp_tlast  = slot0_ff.last_of_run;

   a_step_room: assert property (@(posedge clock) disable iff (reset)
      step |-> (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)))
      else $error("scan step without room in result register");

   a_step_shows: assert property (@(posedge clock) disable iff (reset)
      step && step_res.count != 2'd0 |=> rsp_tvalid)
      else $error("tokens from a step not presented");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !slot0_ff.last_of_run && slot1_ff.last_of_run)
      else $error("token pair with wrong last marks");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_char_ff) && $stable(in_eof_ff))
      else $error("input item lost before scan");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result register over-full");

endmodule
`default_nettype wire
